// File: rtl/core/lsr_pkg.sv
// Shared types and constants for the linear setpoint ramp generator.
// Used by lsr_interp and linear_setpoint_ramp_top; depends on nothing else.
package lsr_pkg;

    localparam int TIME_BITS = 48;
    localparam int SPEED_W   = 16;
    localparam int SPAN_W    = 32;
    localparam int ACC_W     = SPEED_W + 3;    // running high part of the serial product
    localparam int NUM_W     = ACC_W + SPAN_W; // full signed numerator
    localparam int Q_W       = SPEED_W;        // rounded quotient magnitude, at most 2^15

    typedef enum logic
    {
        CMD_BEGIN = 1'b0,
        CMD_EVAL  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_EVAL,
        ST_INTERP,
        ST_OUTPUT
    } top_state_t;

    typedef enum logic [2:0]
    {
        IS_IDLE,
        IS_MUL,
        IS_PREP,
        IS_DIV,
        IS_DONE
    } interp_state_t;

endpackage

// File: rtl/core/linear_setpoint_ramp_top.sv
// Top level of the linear speed setpoint ramp generator: ramp state, command
// decode and output register. Depends on lsr_pkg and lsr_interp.
//
//  Channel  Dir  Sideband             Payload
//  s_*      in   tuser: command       tdata: start_speed, target_speed, now_time, ramp_length
//  m_*      out  tuser: ramp_active   tdata: setpoint
//
// A begin beat is absorbed in the cycle it is accepted and produces no output.
// An evaluate beat that hits the start or target speed passes through the EVAL
// and OUTPUT states to the output register; one that interpolates also waits in
// INTERP for the bit-serial multiply and the bit-serial divide.
// Reset clears the ramp state, so a first evaluate answers 0, not running.
// The input stalls while an evaluate is in progress; a waiting output beat
// does not block a new input beat, only the next result.
module linear_setpoint_ramp_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // start_speed, target_speed, now_time, ramp_length
    input  logic [0:0]   s_tuser,  // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,  // setpoint
    output logic [0:0]   m_tuser   // ramp_active
);

    localparam int TB = lsr_pkg::TIME_BITS;
    localparam int SW = lsr_pkg::SPEED_W;
    localparam int PW = lsr_pkg::SPAN_W;

    lsr_pkg::top_state_t state_reg, state_next;

    logic signed [SW-1:0] start_speed_reg, start_speed_next;
    logic signed [SW-1:0] target_speed_reg, target_speed_next;
    logic                 running_reg, running_next;
    logic [TB-1:0]        start_time_reg, start_time_next;
    logic [TB-1:0]        end_time_reg, end_time_next;
    logic [TB-1:0]        now_reg, now_next;
    logic signed [SW-1:0] sp_reg, sp_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SW-1:0]        out_data_reg, out_data_next;
    logic                 out_active_reg, out_active_next;

    logic                 accept;
    lsr_pkg::cmd_t        in_cmd;
    logic signed [SW-1:0] in_start;
    logic signed [SW-1:0] in_target;
    logic [TB-1:0]        in_now;
    logic [PW-1:0]        in_len;
    logic [TB:0]          end_sum;
    logic [TB-1:0]        end_sat;
    logic                 at_end;
    logic                 at_start;
    logic                 interp_start;
    logic                 interp_done;
    logic signed [SW-1:0] interp_setpoint;
    logic [TB-1:0]        elapsed_w;
    logic [TB-1:0]        span_w;

    assign s_tready = (state_reg == lsr_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign in_cmd    = lsr_pkg::cmd_t'(s_tuser[0]);
    assign in_start  = $signed(s_tdata[15:0]);
    assign in_target = $signed(s_tdata[31:16]);
    assign in_now    = s_tdata[32+TB-1:32];
    assign in_len    = s_tdata[111:80];

    assign end_sum = {1'b0, in_now} + (TB+1)'(in_len);
    assign end_sat = end_sum[TB] ? {TB{1'b1}} : end_sum[TB-1:0];

    assign at_end    = !running_reg || (now_reg >= end_time_reg);
    assign at_start  = (now_reg <= start_time_reg);
    assign elapsed_w = now_reg - start_time_reg;
    assign span_w    = end_time_reg - start_time_reg;

    lsr_interp u_interp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (interp_start),
        .start_speed  (start_speed_reg),
        .target_speed (target_speed_reg),
        .elapsed      (elapsed_w[PW-1:0]),
        .span         (span_w[PW-1:0]),
        .done         (interp_done),
        .setpoint     (interp_setpoint)
    );

    always_comb
    begin
        state_next        = state_reg;
        start_speed_next  = start_speed_reg;
        target_speed_next = target_speed_reg;
        running_next      = running_reg;
        start_time_next   = start_time_reg;
        end_time_next     = end_time_reg;
        now_next          = now_reg;
        sp_next           = sp_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_data_next     = out_data_reg;
        out_active_next   = out_active_reg;
        interp_start      = 1'b0;

        unique case (state_reg)
            lsr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == lsr_pkg::CMD_BEGIN)
                    begin
                        start_speed_next  = in_start;
                        target_speed_next = in_target;
                        start_time_next   = in_now;
                        // A zero length or a flat ramp jumps straight to the target.
                        if ((in_len == '0) || (in_start == in_target))
                        begin
                            running_next  = 1'b0;
                            end_time_next = in_now;
                        end
                        else
                        begin
                            running_next  = 1'b1;
                            end_time_next = end_sat;
                        end
                    end
                    else
                    begin
                        now_next   = in_now;
                        state_next = lsr_pkg::ST_EVAL;
                    end
                end
            end
            lsr_pkg::ST_EVAL:
            begin
                priority if (at_end)
                begin
                    running_next = 1'b0;
                    sp_next      = target_speed_reg;
                    state_next   = lsr_pkg::ST_OUTPUT;
                end
                else if (at_start)
                begin
                    sp_next    = start_speed_reg;
                    state_next = lsr_pkg::ST_OUTPUT;
                end
                else
                begin
                    // Strictly inside the ramp, so span and elapsed fit 32 bits.
                    interp_start = 1'b1;
                    state_next   = lsr_pkg::ST_INTERP;
                end
            end
            lsr_pkg::ST_INTERP:
            begin
                if (interp_done)
                begin
                    sp_next    = interp_setpoint;
                    state_next = lsr_pkg::ST_OUTPUT;
                end
            end
            lsr_pkg::ST_OUTPUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = sp_reg;
                    out_active_next = running_reg;
                    state_next      = lsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsr_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lsr_pkg::ST_IDLE;
            start_speed_reg  <= '0;
            target_speed_reg <= '0;
            running_reg      <= 1'b0;
            start_time_reg   <= '0;
            end_time_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            start_speed_reg  <= start_speed_next;
            target_speed_reg <= target_speed_next;
            running_reg      <= running_next;
            start_time_reg   <= start_time_next;
            end_time_reg     <= end_time_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        sp_reg         <= sp_next;
        out_data_reg   <= out_data_next;
        out_active_reg <= out_active_next;
    end

endmodule

// File: rtl/core/lsr_interp.sv
// Bit-serial interpolation unit: shift-add product of the numerator, then a
// restoring division with round half away from zero. Depends on lsr_pkg.
module lsr_interp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [lsr_pkg::SPEED_W-1:0] start_speed,
    input  logic signed [lsr_pkg::SPEED_W-1:0] target_speed,
    input  logic        [lsr_pkg::SPAN_W-1:0]  elapsed,
    input  logic        [lsr_pkg::SPAN_W-1:0]  span,
    output logic                                done,
    output logic signed [lsr_pkg::SPEED_W-1:0] setpoint
);

    localparam int ACC_W = lsr_pkg::ACC_W;
    localparam int SPAN_W = lsr_pkg::SPAN_W;
    localparam int NUM_W = lsr_pkg::NUM_W;
    localparam int Q_W = lsr_pkg::Q_W;
    localparam int DVD_W = NUM_W + 2;      // doubled numerator plus span, signed
    localparam int REM_W = SPAN_W + 1;     // remainder stays below twice the span
    localparam int CNT_W = $clog2(SPAN_W);

    lsr_pkg::interp_state_t state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    logic signed [ACC_W-1:0]  hi_reg, hi_next;
    logic [SPAN_W-1:0]        lo_reg, lo_next;
    logic [SPAN_W-1:0]        span_reg, span_next;
    logic [SPAN_W-1:0]        span_sh_reg, span_sh_next;
    logic [SPAN_W-1:0]        elap_sh_reg, elap_sh_next;
    logic signed [ACC_W-1:0]  mul_s_reg, mul_s_next;
    logic signed [ACC_W-1:0]  mul_d_reg, mul_d_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [Q_W-1:0]           dlo_reg, dlo_next;
    logic [Q_W-1:0]           q_reg, q_next;
    logic                     neg_reg, neg_next;

    logic signed [ACC_W-1:0]  partial;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [DVD_W-1:0]  num_x2;
    logic signed [DVD_W-1:0]  span_x;
    logic signed [DVD_W-1:0]  dividend;
    logic [REM_W:0]           trial;
    logic [REM_W:0]           divisor;
    logic                     fits;

    always_comb
    begin
        partial = (span_sh_reg[0] ? mul_s_reg : '0) + (elap_sh_reg[0] ? mul_d_reg : '0);
        acc_sum = hi_reg + partial;

        num_x2   = DVD_W'($signed({hi_reg, lo_reg, 1'b0}));
        span_x   = $signed({{(DVD_W-SPAN_W){1'b0}}, span_reg});
        // The rounding dividend is 2*|num| + span in both sign cases.
        dividend = hi_reg[ACC_W-1] ? (span_x - num_x2) : (span_x + num_x2);

        trial   = {rem_reg, dlo_reg[Q_W-1]};
        divisor = {1'b0, span_reg, 1'b0};
        fits    = (trial >= divisor);
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        span_next    = span_reg;
        span_sh_next = span_sh_reg;
        elap_sh_next = elap_sh_reg;
        mul_s_next   = mul_s_reg;
        mul_d_next   = mul_d_reg;
        rem_next     = rem_reg;
        dlo_next     = dlo_reg;
        q_next       = q_reg;
        neg_next     = neg_reg;
        done         = 1'b0;

        unique case (state_reg)
            lsr_pkg::IS_IDLE:
            begin
                if (start)
                begin
                    hi_next      = '0;
                    lo_next      = '0;
                    span_next    = span;
                    span_sh_next = span;
                    elap_sh_next = elapsed;
                    mul_s_next   = ACC_W'(start_speed);
                    mul_d_next   = ACC_W'(target_speed) - ACC_W'(start_speed);
                    cnt_next     = '0;
                    state_next   = lsr_pkg::IS_MUL;
                end
            end
            lsr_pkg::IS_MUL:
            begin
                // One multiplier bit of span and of elapsed per cycle; the low
                // product bits fall out into lo_reg.
                hi_next      = acc_sum >>> 1;
                lo_next      = {acc_sum[0], lo_reg[SPAN_W-1:1]};
                span_sh_next = {span_sh_reg[0], span_sh_reg[SPAN_W-1:1]};
                elap_sh_next = {1'b0, elap_sh_reg[SPAN_W-1:1]};
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SPAN_W - 1))
                begin
                    state_next = lsr_pkg::IS_PREP;
                end
            end
            lsr_pkg::IS_PREP:
            begin
                // The quotient is below 2^Q_W, so the top part of the dividend
                // already sits below the divisor and seeds the remainder.
                neg_next   = hi_reg[ACC_W-1];
                rem_next   = dividend[REM_W+Q_W-1:Q_W];
                dlo_next   = dividend[Q_W-1:0];
                q_next     = '0;
                cnt_next   = '0;
                state_next = lsr_pkg::IS_DIV;
            end
            lsr_pkg::IS_DIV:
            begin
                rem_next = fits ? REM_W'(trial - divisor) : trial[REM_W-1:0];
                dlo_next = {dlo_reg[Q_W-2:0], 1'b0};
                q_next   = {q_reg[Q_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    state_next = lsr_pkg::IS_DONE;
                end
            end
            lsr_pkg::IS_DONE:
            begin
                done       = 1'b1;
                state_next = lsr_pkg::IS_IDLE;
            end
            default:
            begin
                state_next = lsr_pkg::IS_IDLE;
            end
        endcase
    end

    assign setpoint = neg_reg ? $signed(-q_reg) : $signed(q_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsr_pkg::IS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        span_reg    <= span_next;
        span_sh_reg <= span_sh_next;
        elap_sh_reg <= elap_sh_next;
        mul_s_reg   <= mul_s_next;
        mul_d_reg   <= mul_d_next;
        rem_reg     <= rem_next;
        dlo_reg     <= dlo_next;
        q_reg       <= q_next;
        neg_reg     <= neg_next;
    end

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for linear_setpoint_ramp_top: drives begin and evaluate
// beats, predicts every setpoint in a small tracker class and compares them beat by beat.
// Depends on lsr_pkg and the RTL of the ramp generator.
`timescale 1ns / 1ps

class setpoint_tracker;

    typedef struct
    {
        logic signed [15:0] setpoint;
        logic               active;
    } setpoint_t;

    localparam logic [lsr_pkg::TIME_BITS-1:0] TIME_MAX = '1;

    logic signed [15:0]            start_spd;
    logic signed [15:0]            target_spd;
    bit                            running;
    logic [lsr_pkg::TIME_BITS-1:0] t_start;
    logic [lsr_pkg::TIME_BITS-1:0] t_end;
    setpoint_t                     setpoints_due[$];
    int                            errors;

    function new();
        start_spd  = '0;
        target_spd = '0;
        running    = 0;
        t_start    = '0;
        t_end      = '0;
        errors     = 0;
    endfunction

    function void note_mismatch(string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Updates the ramp state for one accepted input beat and queues the
    // setpoint that an evaluate beat must produce.
    function void absorb_beat(lsr_pkg::cmd_t cmd, logic signed [15:0] s_spd,
                              logic signed [15:0] t_spd, logic [47:0] now_raw,
                              logic [31:0] len);
        logic [lsr_pkg::TIME_BITS-1:0] now_t;
        logic [lsr_pkg::TIME_BITS:0]   end_sum;
        longint                        span;
        longint                        elapsed;
        longint                        num;
        longint unsigned               mag;
        longint unsigned               q;
        setpoint_t                     due;
        now_t = now_raw[lsr_pkg::TIME_BITS-1:0];
        if (cmd == lsr_pkg::CMD_BEGIN)
        begin
            start_spd  = s_spd;
            target_spd = t_spd;
            t_start    = now_t;
            if (len == 0 || s_spd == t_spd)
            begin
                running = 0;
                t_end   = now_t;
            end
            else
            begin
                running = 1;
                end_sum = {1'b0, now_t} + len;
                t_end   = end_sum[lsr_pkg::TIME_BITS] ? TIME_MAX
                                                      : end_sum[lsr_pkg::TIME_BITS-1:0];
            end
            return;
        end
        if (!running || now_t >= t_end)
        begin
            running      = 0;
            due.setpoint = target_spd;
        end
        else if (now_t <= t_start)
        begin
            due.setpoint = start_spd;
        end
        else
        begin
            span    = longint'(t_end - t_start);
            elapsed = longint'(now_t - t_start);
            num     = longint'(start_spd) * span
                    + (longint'(target_spd) - longint'(start_spd)) * elapsed;
            mag     = (num < 0) ? -num : num;
            // Round half away from zero on the magnitude, then restore the sign.
            q       = (2 * mag + span) / (2 * span);
            due.setpoint = (num < 0) ? 16'(-q) : 16'(q);
        end
        due.active = running;
        setpoints_due.push_back(due);
    endfunction

    function void check_setpoint(logic [15:0] setpoint, logic active);
        setpoint_t due;
        if (setpoints_due.size() == 0)
        begin
            note_mismatch($sformatf("unexpected output beat setpoint=%0d active=%0b",
                                    $signed(setpoint), active));
            return;
        end
        due = setpoints_due.pop_front();
        if (setpoint !== due.setpoint || active !== due.active)
            note_mismatch($sformatf("setpoint expected %0d active %0b, got %0d active %0b",
                                    due.setpoint, due.active, $signed(setpoint), active));
    endfunction

    function int pending();
        return setpoints_due.size();
    endfunction

endclass

module tb_top;

    import lsr_pkg::*;

    localparam logic [47:0] TIME_TOP   = 48'hFFFF_FFFF_FFFF;
    localparam int          RAMP_BEATS = 1650;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;   // start_speed, target_speed, now_time, ramp_length
    logic [0:0]   s_tuser;   // command
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;   // setpoint
    logic [0:0]   m_tuser;   // ramp_active

    setpoint_tracker sb;
    int              beats_sent;
    bit              no_idle;

    linear_setpoint_ramp_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

    // Presents one beat after a random gap and holds it until it is accepted.
    task automatic send_beat(cmd_t cmd, logic signed [15:0] s_spd,
                             logic signed [15:0] t_spd, logic [47:0] now_t,
                             logic [31:0] len);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {len, now_t, t_spd, s_spd};
        forever
        begin
            @(posedge clk);
            if (s_tready)
                break;
        end
        sb.absorb_beat(cmd, s_spd, t_spd, now_t, len);
        beats_sent++;
        @(negedge clk);
    endtask

    // Evaluate beats carry random junk in the fields that only a begin uses.
    task automatic send_eval(logic [47:0] now_t);
        send_beat(CMD_EVAL, 16'($urandom), 16'($urandom), now_t, $urandom);
    endtask

    function automatic logic signed [15:0] pick_speed();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'($signed($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 9))
            0:          return 32'd0;
            1, 2, 3:    return $urandom_range(1, 16);
            4, 5, 6:    return $urandom_range(1, 5000);
            7, 8:       return $urandom;
            default:    return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [47:0] pick_start_time();
        case ($urandom_range(0, 5))
            0:       return TIME_TOP - $urandom_range(0, 5000);
            1:       return 48'($urandom_range(0, 5000));
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    // Times around the ramp: before, at the start, inside, at and after the end, or at random.
    function automatic logic [47:0] pick_eval_time(logic [47:0] st, logic [31:0] len);
        logic [47:0]     tend;
        longint unsigned r;
        tend = st + len;
        r    = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:          return st - $urandom_range(1, 50);
            1:          return st;
            2, 3, 4, 5: return (len >= 2) ? st + 48'(1 + r % (len - 1)) : st;
            6:          return tend;
            7:          return tend + $urandom_range(1, 50);
            8:          return tend - 1;
            default:    return 48'({$urandom, $urandom});
        endcase
    endfunction

    task automatic run_ramp();
        logic signed [15:0] s_spd;
        logic signed [15:0] t_spd;
        logic [47:0]        st;
        logic [31:0]        len;
        int                 evals;
        s_spd = pick_speed();
        t_spd = ($urandom_range(0, 15) == 0) ? s_spd : pick_speed();
        st    = pick_start_time();
        len   = pick_length();
        evals = $urandom_range(1, 8);
        send_beat(CMD_BEGIN, s_spd, t_spd, st, len);
        repeat (evals)
            send_eval(pick_eval_time(st, len));
    endtask

    // Output side: stalls a random number of cycles before taking each beat.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            forever
            begin
                @(posedge clk);
                if (m_tvalid)
                    break;
            end
            sb.check_setpoint(m_tdata, m_tuser[0]);
            @(negedge clk);
        end
    end

    initial
    begin
        sb         = new();
        beats_sent = 0;
        no_idle    = 0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_BEGIN;
        rst_n      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Evaluate straight after reset: target is zero and nothing runs.
        send_eval(48'd0);

        // Full-scale ramp over the longest length, probed across its whole span.
        send_beat(CMD_BEGIN, 16'sh8000, 16'sh7FFF, 48'd1000, 32'hFFFF_FFFF);
        send_eval(48'd999);
        send_eval(48'd1000);
        send_eval(48'd1001);
        send_eval(48'd1000 + 48'h7FFF_FFFF);
        send_eval(48'd1000 + 48'hFFFF_FFFE);
        send_eval(48'd1000 + 48'hFFFF_FFFF);
        send_eval(48'd1500);

        // Exact halves must round away from zero in both directions.
        send_beat(CMD_BEGIN, 16'sd0, 16'sd1, 48'd0, 32'd2);
        send_eval(48'd1);
        send_beat(CMD_BEGIN, 16'sd0, -16'sd1, 48'd0, 32'd2);
        send_eval(48'd1);

        // Equal speeds and a zero length both leave the ramp idle.
        send_beat(CMD_BEGIN, 16'sd5, 16'sd5, 48'd10, 32'd100);
        send_eval(48'd20);
        send_beat(CMD_BEGIN, 16'sd100, -16'sd100, 48'd50, 32'd0);
        send_eval(48'd40);

        // End time clipped at the top of the time range.
        send_beat(CMD_BEGIN, 16'sh7FFF, 16'sh8000, TIME_TOP - 10, 32'd1000);
        send_eval(TIME_TOP - 5);
        send_eval(TIME_TOP);

        // End time clipped all the way down to the start time.
        send_beat(CMD_BEGIN, 16'sd1, 16'sd2, TIME_TOP, 32'd5);
        send_eval(TIME_TOP - 1);
        send_eval(TIME_TOP);

        while (beats_sent < RAMP_BEATS)
        begin
            no_idle = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) < 8)
                run_ramp();
            else if ($urandom_range(0, 1) == 0)
                send_eval(48'({$urandom, $urandom}));
            else
                send_beat(CMD_BEGIN, 16'($urandom), 16'($urandom),
                          48'({$urandom, $urandom}), $urandom);
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
